>>> design/avc2ab_pkg.sv
// Shared types and constants of the length-prefix to start-code converter.
// Used by every module of the block but the RAM; depends on nothing.
`default_nettype none
package avc2ab_pkg;

  localparam int BLOB_BYTES = 128;
  localparam int BLOB_AW = $clog2(BLOB_BYTES);
  localparam int LEN_W = $clog2(BLOB_BYTES + 1);
  localparam int POS_W = $clog2(BLOB_BYTES + 6);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_PKT_DONE = 3'd1;
  localparam logic [2:0] ST_PKT_BAD  = 3'd2;
  localparam logic [2:0] ST_REC_OK   = 3'd3;
  localparam logic [2:0] ST_REC_BAD  = 3'd4;

  localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;
  localparam logic [31:0] START_CODE = 32'h0000_0001;
  localparam logic [7:0] AVCC_VERSION = 8'd1;
  localparam logic [1:0] PREFIX_SIZE_BAD = 2'd2;

  typedef enum logic [3:0] {
    RP_HEADER, RP_LENGTH, RP_SPSCOUNT, RP_SIZEHI, RP_SIZELO,
    RP_UNIT, RP_PPSCOUNT, RP_DONE, RP_BAD
  } rec_phase_t;

  typedef enum logic [1:0] {PP_PREFIX, PP_PAYLOAD, PP_DROP} pkt_phase_t;

  typedef enum logic [1:0] {BK_RUN, BK_FETCH, BK_APPEND, BK_EMIT} back_state_t;

  typedef struct packed {
    logic             sc;
    logic             has_byte;
    logic             blob;
    logic [7:0]       data;
    logic [2:0]       status;
    logic [LEN_W-1:0] blob_len;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [BLOB_AW-1:0] addr;
    logic [7:0]         data;
  } blob_wr_t;

endpackage
`default_nettype wire

>>> design/avc2ab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module avc2ab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/avc2ab_front.sv
// Front end: parses record and packet bytes, keeps the conversion state,
// fills the parameter-set memory and issues jobs. Depends on avc2ab_pkg.
`default_nettype none
module avc2ab_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                cmd,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                q_full,
  input  logic                q_empty,
  output logic                full,
  output logic                job_push,
  output avc2ab_pkg::job_t     job,
  output avc2ab_pkg::blob_wr_t blob_wr
);
  import avc2ab_pkg::*;

  logic               converting, converting_next;
  logic [2:0]         prefix_bytes, prefix_bytes_next;
  logic               idr_pending, idr_pending_next;
  logic [LEN_W-1:0]   blob_length, blob_length_next;
  pkt_phase_t         packet_phase, packet_phase_next;
  logic [2:0]         byte_counter, byte_counter_next;
  logic [31:0]        nal_remaining, nal_remaining_next;
  rec_phase_t         record_phase, record_phase_next;
  logic [2:0]         record_offset, record_offset_next;
  logic [7:0]         units_left, units_left_next;
  logic [15:0]        unit_remaining, unit_remaining_next;
  logic               pps_phase, pps_phase_next;
  logic [2:0]         fill_cnt, fill_cnt_next;
  logic [BLOB_AW-1:0] fill_addr, fill_addr_next;
  logic               accept;

  assign full = (fill_cnt != 3'd0) || q_full || ((cmd == CMD_RECORD) && !q_empty);
  assign accept = push && !full;

  always_comb begin
    logic [15:0] usize;
    logic [16:0] need;
    logic [7:0]  ul;
    logic        unit_end;
    logic [31:0] nr;
    logic [2:0]  bcn;
    logic [2:0]  st;
    converting_next     = converting;
    prefix_bytes_next   = prefix_bytes;
    idr_pending_next    = idr_pending;
    blob_length_next    = blob_length;
    packet_phase_next   = packet_phase;
    byte_counter_next   = byte_counter;
    nal_remaining_next  = nal_remaining;
    record_phase_next   = record_phase;
    record_offset_next  = record_offset;
    units_left_next     = units_left;
    unit_remaining_next = unit_remaining;
    pps_phase_next      = pps_phase;
    fill_cnt_next       = fill_cnt;
    fill_addr_next      = fill_addr;
    job                 = '0;
    job.blob_len        = blob_length;
    job_push            = 1'b0;
    blob_wr             = '0;
    usize    = {unit_remaining[15:8], data_byte};
    need     = 17'(blob_length) + 17'd4 + 17'(usize);
    ul       = units_left;
    unit_end = 1'b0;
    nr       = {nal_remaining[23:0], data_byte};
    bcn      = byte_counter + 3'd1;
    st       = ST_DATA;

    if (fill_cnt != 3'd0) begin
      blob_wr.we     = 1'b1;
      blob_wr.addr   = fill_addr;
      blob_wr.data   = (fill_cnt == 3'd1) ? 8'd1 : 8'd0;
      fill_cnt_next  = fill_cnt - 3'd1;
      fill_addr_next = fill_addr + BLOB_AW'(1);
    end

    if (accept && cmd == CMD_RECORD) begin
      packet_phase_next  = PP_PREFIX;
      byte_counter_next  = 3'd0;
      nal_remaining_next = 32'd0;
      if (record_phase == RP_HEADER && record_offset == 3'd0) begin
        converting_next     = 1'b0;
        blob_length_next    = '0;
        pps_phase_next      = 1'b0;
        units_left_next     = 8'd0;
        unit_remaining_next = 16'd0;
      end
      unique case (record_phase)
        RP_HEADER: begin
          if (record_offset == 3'd0 && data_byte != AVCC_VERSION) begin
            record_phase_next = RP_BAD;
          end else if (record_offset >= 3'd3) begin
            record_phase_next  = RP_LENGTH;
            record_offset_next = 3'd0;
          end else begin
            record_offset_next = record_offset + 3'd1;
          end
        end
        RP_LENGTH: begin
          if (data_byte[1:0] == PREFIX_SIZE_BAD) begin
            record_phase_next = RP_BAD;
          end else begin
            prefix_bytes_next = {1'b0, data_byte[1:0]} + 3'd1;
            record_phase_next = RP_SPSCOUNT;
          end
        end
        RP_SPSCOUNT: begin
          units_left_next = {3'b000, data_byte[4:0]};
          if (data_byte[4:0] == 5'd0) begin
            pps_phase_next    = 1'b1;
            record_phase_next = RP_PPSCOUNT;
          end else begin
            record_phase_next = RP_SIZEHI;
          end
        end
        RP_PPSCOUNT: begin
          units_left_next   = data_byte;
          record_phase_next = (data_byte == 8'd0) ? RP_DONE : RP_SIZEHI;
        end
        RP_SIZEHI: begin
          unit_remaining_next = {data_byte, 8'h00};
          record_phase_next   = RP_SIZELO;
        end
        RP_SIZELO: begin
          unit_remaining_next = usize;
          if (need > 17'(BLOB_BYTES)) begin
            record_phase_next = RP_BAD;
          end else begin
            fill_cnt_next    = 3'd4;
            fill_addr_next   = blob_length[BLOB_AW-1:0];
            blob_length_next = blob_length + LEN_W'(4);
            ul               = units_left - 8'd1;
            units_left_next  = ul;
            if (usize == 16'd0) begin
              unit_end = 1'b1;
            end else begin
              record_phase_next = RP_UNIT;
            end
          end
        end
        RP_UNIT: begin
          if (blob_length < LEN_W'(BLOB_BYTES)) begin
            blob_wr.we       = 1'b1;
            blob_wr.addr     = blob_length[BLOB_AW-1:0];
            blob_wr.data     = data_byte;
            blob_length_next = blob_length + LEN_W'(1);
          end
          unit_remaining_next = unit_remaining - 16'd1;
          if (unit_remaining == 16'd1) begin
            unit_end = 1'b1;
          end
        end
        RP_DONE: begin
        end
        default: begin
          record_phase_next = RP_BAD;
        end
      endcase
      if (unit_end) begin
        if (ul != 8'd0) begin
          record_phase_next = RP_SIZEHI;
        end else if (pps_phase) begin
          record_phase_next = RP_DONE;
        end else begin
          pps_phase_next    = 1'b1;
          record_phase_next = RP_PPSCOUNT;
        end
      end
      if (last_byte) begin
        if (record_phase_next == RP_DONE) begin
          converting_next  = 1'b1;
          idr_pending_next = 1'b1;
          job.status       = ST_REC_OK;
        end else begin
          converting_next  = 1'b0;
          blob_length_next = '0;
          job.status       = ST_REC_BAD;
        end
        job_push            = 1'b1;
        record_phase_next   = RP_HEADER;
        record_offset_next  = 3'd0;
        pps_phase_next      = 1'b0;
        units_left_next     = 8'd0;
        unit_remaining_next = 16'd0;
      end
    end else if (accept && !converting) begin
      job.has_byte = 1'b1;
      job.data     = data_byte;
      job.status   = last_byte ? ST_PKT_DONE : ST_DATA;
      job_push     = 1'b1;
    end else if (accept) begin
      job.data = data_byte;
      unique case (packet_phase)
        PP_PAYLOAD: begin
          if (byte_counter == 3'd0) begin
            if (idr_pending && data_byte[4:0] == NAL_TYPE_IDR) begin
              job.blob         = (blob_length != '0);
              idr_pending_next = 1'b0;
            end else if (!idr_pending && data_byte[4:0] == NAL_TYPE_SLICE) begin
              idr_pending_next = 1'b1;
            end
            job.sc            = 1'b1;
            byte_counter_next = 3'd1;
          end
          job.has_byte       = 1'b1;
          nal_remaining_next = nal_remaining - 32'd1;
          if (nal_remaining == 32'd1) begin
            packet_phase_next = PP_PREFIX;
            byte_counter_next = 3'd0;
            st = last_byte ? ST_PKT_DONE : ST_DATA;
          end else begin
            st = last_byte ? ST_PKT_BAD : ST_DATA;
          end
        end
        PP_DROP: begin
          st = last_byte ? ST_PKT_BAD : ST_DATA;
        end
        default: begin
          nal_remaining_next = nr;
          byte_counter_next  = bcn;
          if (bcn >= prefix_bytes) begin
            byte_counter_next = 3'd0;
            if (prefix_bytes >= 3'd4 && nr[31]) begin
              packet_phase_next = PP_DROP;
              st = last_byte ? ST_PKT_BAD : ST_DATA;
            end else if (nr == 32'd0) begin
              packet_phase_next = PP_PREFIX;
              job.sc = 1'b1;
              st = last_byte ? ST_PKT_DONE : ST_DATA;
            end else begin
              packet_phase_next = PP_PAYLOAD;
              st = last_byte ? ST_PKT_BAD : ST_DATA;
            end
          end else begin
            st = last_byte ? ST_PKT_BAD : ST_DATA;
          end
        end
      endcase
      job.status = st;
      job_push   = job.sc || job.has_byte || last_byte;
      if (last_byte) begin
        packet_phase_next  = PP_PREFIX;
        byte_counter_next  = 3'd0;
        nal_remaining_next = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      converting     <= 1'b0;
      prefix_bytes   <= 3'd4;
      idr_pending    <= 1'b1;
      blob_length    <= '0;
      packet_phase   <= PP_PREFIX;
      byte_counter   <= 3'd0;
      nal_remaining  <= 32'd0;
      record_phase   <= RP_HEADER;
      record_offset  <= 3'd0;
      units_left     <= 8'd0;
      unit_remaining <= 16'd0;
      pps_phase      <= 1'b0;
      fill_cnt       <= 3'd0;
      fill_addr      <= '0;
    end else begin
      converting     <= converting_next;
      prefix_bytes   <= prefix_bytes_next;
      idr_pending    <= idr_pending_next;
      blob_length    <= blob_length_next;
      packet_phase   <= packet_phase_next;
      byte_counter   <= byte_counter_next;
      nal_remaining  <= nal_remaining_next;
      record_phase   <= record_phase_next;
      record_offset  <= record_offset_next;
      units_left     <= units_left_next;
      unit_remaining <= unit_remaining_next;
      pps_phase      <= pps_phase_next;
      fill_cnt       <= fill_cnt_next;
      fill_addr      <= fill_addr_next;
    end
  end

endmodule
`default_nettype wire

>>> design/avc2ab_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on avc2ab_pkg.
`default_nettype none
module avc2ab_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  avc2ab_pkg::job_t wr_job,
  input  logic            rd,
  output avc2ab_pkg::job_t head,
  output logic            q_empty,
  output logic            q_full
);
  import avc2ab_pkg::*;

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign head    = slots[rptr];
  assign q_empty = (cnt == 2'd0);
  assign q_full  = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

>>> design/avc2ab_back.sv
// Back end: turns jobs into packed result words, reading the parameter-set
// memory when a set must be inserted. Depends on avc2ab_pkg.
`default_nettype none
module avc2ab_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  avc2ab_pkg::job_t            head,
  output logic                       q_pop,
  output logic                       ram_re,
  output logic [avc2ab_pkg::BLOB_AW-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  input  logic                       pop,
  output logic                       empty,
  output logic [31:0]                out_word,
  output logic [2:0]                 out_count,
  output logic                       end_of_run,
  output logic [2:0]                 status
);
  import avc2ab_pkg::*;

  back_state_t      state, state_next;
  logic             sc_done, sc_done_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      acc, acc_next;
  logic [2:0]       nb, nb_next;
  logic             out_valid;
  logic             slot_free;
  logic             ld;
  logic [31:0]      ld_word;
  logic [2:0]       ld_count;
  logic             ld_end;
  logic [2:0]       ld_status;
  logic [POS_W-1:0] blen;
  logic             done;
  logic             last_pos;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign blen      = POS_W'(head.blob_len);
  assign done      = (pos == blen + POS_W'(5));
  assign last_pos  = (pos == blen + POS_W'(4));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (!q_empty && head.blob) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_next = BK_APPEND;
      end
      BK_APPEND: begin
        state_next = (nb == 3'd3 || last_pos) ? BK_EMIT : BK_FETCH;
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_next = done ? BK_RUN : BK_FETCH;
        end
      end
    endcase
  end

  always_comb begin
    logic [7:0] b;
    b = head.data;
    sc_done_next = sc_done;
    pos_next     = pos;
    acc_next     = acc;
    nb_next      = nb;
    q_pop        = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = pos[BLOB_AW-1:0];
    ld           = 1'b0;
    ld_word      = 32'd0;
    ld_count     = 3'd0;
    ld_end       = 1'b0;
    ld_status    = ST_DATA;
    unique case (state)
      BK_RUN: begin
        pos_next = '0;
        acc_next = 32'd0;
        nb_next  = 3'd0;
        if (!q_empty && !head.blob && slot_free) begin
          ld = 1'b1;
          if (head.sc && !sc_done) begin
            ld_word   = START_CODE;
            ld_count  = 3'd4;
            ld_end    = !head.has_byte;
            ld_status = head.has_byte ? ST_DATA : head.status;
            if (head.has_byte) begin
              sc_done_next = 1'b1;
            end else begin
              q_pop = 1'b1;
            end
          end else begin
            ld_word      = head.has_byte ? {head.data, 24'd0} : 32'd0;
            ld_count     = head.has_byte ? 3'd1 : 3'd0;
            ld_end       = 1'b1;
            ld_status    = head.status;
            sc_done_next = 1'b0;
            q_pop        = 1'b1;
          end
        end
      end
      BK_FETCH: begin
        ram_re = (pos < blen);
      end
      BK_APPEND: begin
        if (pos < blen) begin
          b = ram_rdata;
        end else if (pos < blen + POS_W'(4)) begin
          b = (pos == blen + POS_W'(3)) ? 8'd1 : 8'd0;
        end
        acc_next = acc | ({b, 24'd0} >> {nb[1:0], 3'b000});
        nb_next  = nb + 3'd1;
        pos_next = pos + POS_W'(1);
      end
      BK_EMIT: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_word   = acc;
          ld_count  = nb;
          ld_end    = done;
          ld_status = done ? head.status : ST_DATA;
          acc_next  = 32'd0;
          nb_next   = 3'd0;
          q_pop     = done;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      sc_done   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      sc_done <= sc_done_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    acc <= acc_next;
    nb  <= nb_next;
    if (ld) begin
      out_word   <= ld_word;
      out_count  <= ld_count;
      end_of_run <= ld_end;
      status     <= ld_status;
    end
  end

endmodule
`default_nettype wire

>>> design/h264_avcc_to_annexb.sv
// Length-prefixed to start-code converter: an accepted item goes through the job queue and
// then the output register. Packet bytes go through at one item a cycle while neither is held;
// a NAL start with a first byte gives two results (start code and byte). Inserting the sets
// fetches and appends each inserted byte (stored sets, start code and NAL byte) in turn, set
// by the single read port of the set memory, and emits a word per four bytes or at the end.
// Record bytes wait until the job queue is empty, and each stored unit holds input while its
// start code is written. Reset is synchronous; the memory is not cleared.
`default_nettype none
module h264_avcc_to_annexb (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_word,
  output logic [2:0]  out_count,
  output logic        end_of_run,
  output logic [2:0]  status
);
  import avc2ab_pkg::*;

  job_t               fe_job;
  logic               fe_push;
  blob_wr_t           blob_wr;
  job_t               q_head;
  logic               q_empty;
  logic               q_full;
  logic               q_pop;
  logic               ram_re;
  logic [BLOB_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  avc2ab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (cmd),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .full      (full),
    .job_push  (fe_push),
    .job       (fe_job),
    .blob_wr   (blob_wr)
  );

  avc2ab_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fe_push),
    .wr_job  (fe_job),
    .rd      (q_pop),
    .head    (q_head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  avc2ab_ram #(
    .WIDTH (8),
    .DEPTH (BLOB_BYTES)
  ) u_blob_ram (
    .clk   (clk),
    .we    (blob_wr.we),
    .waddr (blob_wr.addr),
    .wdata (blob_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  avc2ab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (q_head),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .pop        (pop),
    .empty      (empty),
    .out_word   (out_word),
    .out_count  (out_count),
    .end_of_run (end_of_run),
    .status     (status)
  );

endmodule
`default_nettype wire

>>> bench/h264_avcc_to_annexb_tb.sv
// Self-checking bench for the length-prefix to start-code converter.
// It depends on avc2ab_pkg and h264_avcc_to_annexb. It drives record and packet items
// through a queue-style interface, predicts every result word and checks it field by field.
`timescale 1ns / 100ps
`default_nettype none
module h264_avcc_to_annexb_tb;
  import avc2ab_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] b;
    logic       last;
    bit         sync;
    int         sidle;
    int         ridle;
  } byte_item_t;

  typedef struct {
    logic [31:0] w;
    logic [2:0]  n;
    logic        eor;
    logic [2:0]  st;
  } out_word_t;

  logic clk = 1'b0, rst = 1'b1;
  logic push = 1'b0, cmd = 1'b0, last_byte = 1'b0, pop = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic full, empty, end_of_run;
  logic [31:0] out_word;
  logic [2:0] out_count, status;

  h264_avcc_to_annexb dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .data_byte(data_byte),
    .last_byte(last_byte), .empty(empty), .pop(pop), .out_word(out_word),
    .out_count(out_count), .end_of_run(end_of_run), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_item_t stim_q[$];
  out_word_t expected_q[$];
  out_word_t step_q[$];
  bit failed = 0;
  bit took = 0;
  int accepted = 0;
  int send_idle = 36, recv_idle = 82;
  int hold_left = 0;
  bit hold_done = 0;

  // Predictor state.
  bit         conv;
  int         pfx_size;
  bit         idr_armed;
  logic [7:0] sets[BLOB_BYTES];
  int         sets_len;
  pkt_phase_t pphase;
  int         pcount;
  logic [31:0] nal_left;
  rec_phase_t rphase;
  int         roff;
  logic [7:0] units;
  logic [15:0] unit_left;
  bit         in_pps;
  logic [31:0] acc_word;
  int         acc_n;

  function automatic void flush_word();
    out_word_t r;
    if (acc_n == 0) return;
    r.w = acc_word; r.n = acc_n[2:0]; r.eor = 1'b0; r.st = ST_DATA;
    step_q.push_back(r);
    acc_word = 32'd0; acc_n = 0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    acc_word |= {24'd0, b} << (24 - 8 * acc_n);
    acc_n++;
    if (acc_n == 4) flush_word();
  endfunction

  function automatic void put_start();
    put_byte(8'd0); put_byte(8'd0); put_byte(8'd0); put_byte(8'd1);
  endfunction

  function automatic void store_set_byte(logic [7:0] b);
    if (sets_len < BLOB_BYTES) begin
      sets[sets_len] = b;
      sets_len++;
    end
  endfunction

  function automatic void unit_finished();
    if (units != 0) rphase = RP_SIZEHI;
    else if (in_pps) rphase = RP_DONE;
    else begin
      in_pps = 1; rphase = RP_PPSCOUNT;
    end
  endfunction

  function automatic void packet_reset();
    pphase = PP_PREFIX; pcount = 0; nal_left = 32'd0;
  endfunction

  function automatic logic [2:0] record_step(logic [7:0] b, logic last);
    logic [2:0] st;
    packet_reset();
    if (rphase == RP_HEADER && roff == 0) begin
      conv = 0; sets_len = 0; in_pps = 0; units = 8'd0; unit_left = 16'd0;
    end
    case (rphase)
      RP_HEADER: begin
        if (roff == 0 && b != AVCC_VERSION) rphase = RP_BAD;
        else if (roff >= 3) begin
          rphase = RP_LENGTH; roff = 0;
        end else roff++;
      end
      RP_LENGTH: begin
        if (b[1:0] == PREFIX_SIZE_BAD) rphase = RP_BAD;
        else begin
          pfx_size = b[1:0] + 1; rphase = RP_SPSCOUNT;
        end
      end
      RP_SPSCOUNT: begin
        units = {3'd0, b[4:0]};
        if (units == 0) begin
          in_pps = 1; rphase = RP_PPSCOUNT;
        end else rphase = RP_SIZEHI;
      end
      RP_PPSCOUNT: begin
        units = b;
        rphase = (b == 0) ? RP_DONE : RP_SIZEHI;
      end
      RP_SIZEHI: begin
        unit_left = {b, 8'd0}; rphase = RP_SIZELO;
      end
      RP_SIZELO: begin
        unit_left[7:0] = b;
        if (sets_len + 4 + int'(unit_left) > BLOB_BYTES) rphase = RP_BAD;
        else begin
          store_set_byte(8'd0); store_set_byte(8'd0);
          store_set_byte(8'd0); store_set_byte(8'd1);
          units--;
          if (unit_left == 0) unit_finished();
          else rphase = RP_UNIT;
        end
      end
      RP_UNIT: begin
        store_set_byte(b);
        unit_left--;
        if (unit_left == 0) unit_finished();
      end
      RP_DONE: ;
      default: rphase = RP_BAD;
    endcase
    if (!last) return ST_DATA;
    if (rphase == RP_DONE) begin
      conv = 1; idr_armed = 1; st = ST_REC_OK;
    end else begin
      conv = 0; sets_len = 0; st = ST_REC_BAD;
    end
    rphase = RP_HEADER; roff = 0; in_pps = 0; units = 8'd0; unit_left = 16'd0;
    return st;
  endfunction

  function automatic logic [2:0] packet_step(logic [7:0] b, logic last);
    logic [2:0] st = ST_DATA;
    if (!conv) begin
      put_byte(b);
      return last ? ST_PKT_DONE : ST_DATA;
    end
    case (pphase)
      PP_PAYLOAD: begin
        if (pcount == 0) begin
          if (idr_armed && b[4:0] == NAL_TYPE_IDR) begin
            for (int i = 0; i < sets_len; i++) put_byte(sets[i]);
            idr_armed = 0;
          end else if (!idr_armed && b[4:0] == NAL_TYPE_SLICE) idr_armed = 1;
          put_start();
          pcount = 1;
        end
        put_byte(b);
        nal_left--;
        if (nal_left == 0) begin
          pphase = PP_PREFIX; pcount = 0;
          if (last) st = ST_PKT_DONE;
        end else if (last) st = ST_PKT_BAD;
      end
      PP_DROP: if (last) st = ST_PKT_BAD;
      default: begin
        nal_left = {nal_left[23:0], b};
        pcount++;
        if (pcount >= pfx_size) begin
          pcount = 0;
          if (pfx_size >= 4 && nal_left[31]) begin
            pphase = PP_DROP;
            if (last) st = ST_PKT_BAD;
          end else if (nal_left == 0) begin
            put_start();
            if (last) st = ST_PKT_DONE;
          end else begin
            pphase = PP_PAYLOAD;
            if (last) st = ST_PKT_BAD;
          end
        end else if (last) st = ST_PKT_BAD;
      end
    endcase
    if (last) packet_reset();
    return st;
  endfunction

  function automatic void predict_item(logic c, logic [7:0] b, logic last);
    logic [2:0] st;
    step_q.delete();
    acc_word = 32'd0; acc_n = 0;
    st = (c == CMD_RECORD) ? record_step(b, last) : packet_step(b, last);
    flush_word();
    if (step_q.size() == 0 && st != ST_DATA) step_q.push_back('{32'd0, 3'd0, 1'b0, ST_DATA});
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].eor = 1'b1;
      step_q[step_q.size() - 1].st = st;
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // Stimulus generation.
  int phase_sidle = 36, phase_ridle = 82;
  bit next_sync = 0;
  int gen_pfx = 4;

  task automatic add(logic c, logic [7:0] b, logic last);
    stim_q.push_back('{c, b, last, next_sync, phase_sidle, phase_ridle});
    next_sync = 0;
  endtask

  task automatic send_bytes(logic c, ref logic [7:0] bs[$]);
    foreach (bs[i]) add(c, bs[i], i == bs.size() - 1);
  endtask

  // Builds a record whose units all have the given size; cut > 0 truncates it to that many bytes.
  task automatic gen_record(int lsel, int nsps, int npps, int usz, int cut, int trail);
    logic [7:0] bs[$];
    bs.push_back(AVCC_VERSION);
    repeat (3) bs.push_back(8'($urandom));
    bs.push_back({6'($urandom_range(63)), lsel[1:0]});
    bs.push_back({3'($urandom_range(7)), nsps[4:0]});
    for (int u = 0; u < nsps + npps; u++) begin
      if (u == nsps) bs.push_back(npps[7:0]);
      bs.push_back(8'(usz >> 8)); bs.push_back(8'(usz));
      repeat (usz) bs.push_back(8'($urandom));
    end
    if (nsps + npps == nsps) bs.push_back(8'd0);
    repeat (trail) bs.push_back(8'($urandom));
    while (cut > 0 && bs.size() > cut) void'(bs.pop_back());
    if (lsel != 2 && cut == 0 && usz * (nsps + npps) + 4 * (nsps + npps) <= BLOB_BYTES)
      gen_pfx = lsel + 1;
    send_bytes(CMD_RECORD, bs);
  endtask

  task automatic gen_packet(int nnal, int maxlen, int ftype, int cut, bit neg);
    logic [7:0] bs[$];
    int len;
    for (int k = 0; k < nnal; k++) begin
      len = $urandom_range(maxlen);
      if (gen_pfx == 1 && len > 255) len = 255;
      for (int j = gen_pfx - 1; j >= 0; j--)
        bs.push_back((neg && j == 3) ? 8'h80 | 8'($urandom) : 8'(len >> (8 * j)));
      if (neg) begin
        repeat (3) bs.push_back(8'($urandom));
        break;
      end
      for (int j = 0; j < len; j++) begin
        if (j == 0 && ftype >= 0) bs.push_back({3'($urandom_range(7)), ftype[4:0]});
        else bs.push_back(8'($urandom));
      end
    end
    while (cut > 0 && bs.size() > cut) void'(bs.pop_back());
    if (bs.size() == 0) bs.push_back(8'($urandom));
    send_bytes(CMD_PACKET, bs);
  endtask

  initial begin
    logic [7:0] bs[$];
    int r;
    bs = '{8'h00, 8'hff};
    send_bytes(CMD_PACKET, bs);
    bs = '{8'h02, 8'h00};
    send_bytes(CMD_RECORD, bs);
    gen_record(2, 1, 1, 1, 0, 0);
    gen_record(3, 1, 1, 2, 0, 1);
    gen_packet(1, 3, NAL_TYPE_IDR, 0, 0);
    gen_packet(1, 0, -1, 0, 0);
    gen_packet(1, 4, NAL_TYPE_SLICE, 6, 0);
    add(CMD_RECORD, 8'h00, 1'b1);
    gen_record(0, 1, 0, 2, 0, 0);
    gen_packet(1, 2, NAL_TYPE_IDR, 0, 0);
    while (stim_q.size() < 150) begin
      if (stim_q.size() > 70) begin
        phase_sidle = 82; phase_ridle = 36;
      end
      if (stim_q.size() > 115) begin
        phase_sidle = 0; phase_ridle = 0;
      end
      if (stim_q.size() > 90 && stim_q.size() < 105) next_sync = 1;
      r = $urandom_range(99);
      if (r < 12)
        gen_record($urandom_range(3), $urandom_range(2), $urandom_range(2),
                   $urandom_range(12), ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 0,
                   $urandom_range(1));
      else if (r < 14) gen_record(3, 1, 0, 130, 12, 0);
      else if (r < 18) begin
        add(CMD_RECORD, 8'($urandom), 1'($urandom_range(1)));
      end else
        gen_packet($urandom_range(1, 3), $urandom_range(6),
                   ($urandom_range(3) == 0) ? -1 : ($urandom_range(1) ? 5 : 1),
                   ($urandom_range(7) == 0) ? $urandom_range(1, 5) : 0,
                   gen_pfx == 4 && $urandom_range(11) == 0);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_q.size() == 0);
    @(posedge clk);
    wait (!push && expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("status: fail");
    $finish;
  end

  // Driver: presents items at the falling edge.
  always @(negedge clk) begin
    if (rst) push <= 1'b0;
    else if (!push || took) begin
      if (stim_q.size() == 0 || $urandom_range(99) < send_idle) push <= 1'b0;
      else if (stim_q[0].sync && expected_q.size() != 0) push <= 1'b0;
      else begin
        byte_item_t it;
        it = stim_q.pop_front();
        send_idle = it.sidle;
        recv_idle = it.ridle;
        cmd <= it.cmd;
        data_byte <= it.b;
        last_byte <= it.last;
        push <= 1'b1;
      end
    end
  end

  // Receiver, with one long hold-off once the run is under way.
  always @(negedge clk) begin
    if (!hold_done && accepted >= 40) begin
      hold_done <= 1;
      hold_left <= 300;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else pop <= !rst && $urandom_range(99) >= recv_idle;
  end

  // Monitor: predicts on accepted items and checks popped results.
  always @(posedge clk) begin
    if (rst) begin
      conv = 0; pfx_size = 4; idr_armed = 1; sets_len = 0;
      packet_reset();
      rphase = RP_HEADER; roff = 0; units = 8'd0; unit_left = 16'd0; in_pps = 0;
      took <= 1'b0;
    end else begin
      took <= push && !full;
      if (push && !full) begin
        predict_item(cmd, data_byte, last_byte);
        accepted <= accepted + 1;
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result with no item expected: word %h", out_word);
          failed = 1;
        end else begin
          out_word_t e;
          e = expected_q.pop_front();
          if (out_word !== e.w) begin
            $error("out_word expected %h got %h", e.w, out_word); failed = 1;
          end
          if (out_count !== e.n) begin
            $error("out_count expected %0d got %0d", e.n, out_count); failed = 1;
          end
          if (end_of_run !== e.eor) begin
            $error("end_of_run expected %0d got %0d", e.eor, end_of_run); failed = 1;
          end
          if (status !== e.st) begin
            $error("status expected %0d got %0d", e.st, status); failed = 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> files.f
design/avc2ab_pkg.sv
design/avc2ab_ram.sv
design/avc2ab_front.sv
design/avc2ab_queue.sv
design/avc2ab_back.sv
design/h264_avcc_to_annexb.sv
bench/h264_avcc_to_annexb_tb.sv
